>>> rtl/cnu_pkg.sv
// Shared types, codes and helper functions of the numeric conversion unit.
package cnu_pkg;

	localparam int CMD_W   = 4;
	localparam int STYPE_W = 3;
	localparam int VAL_W   = 64;
	localparam int RTYPE_W = 3;
	localparam int QDEPTH  = 2;

	// conversion commands
	localparam logic [CMD_W-1:0] CMD_I   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_U   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_I1  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_U1  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_I2  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_U2  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_I4  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_U4  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_I8  = 4'd8;
	localparam logic [CMD_W-1:0] CMD_U8  = 4'd9;
	localparam logic [CMD_W-1:0] CMD_R4  = 4'd10;
	localparam logic [CMD_W-1:0] CMD_R8  = 4'd11;
	localparam logic [CMD_W-1:0] CMD_RUN = 4'd12;

	// source stack types
	localparam logic [STYPE_W-1:0] ST_VALUETYPE = 3'd0;
	localparam logic [STYPE_W-1:0] ST_NATIVE    = 3'd1;
	localparam logic [STYPE_W-1:0] ST_INT32     = 3'd2;
	localparam logic [STYPE_W-1:0] ST_INT64     = 3'd3;
	localparam logic [STYPE_W-1:0] ST_F32       = 3'd4;
	localparam logic [STYPE_W-1:0] ST_F64       = 3'd5;
	localparam logic [STYPE_W-1:0] ST_OBJECT    = 3'd6;
	localparam logic [STYPE_W-1:0] ST_POINTER   = 3'd7;

	// result stack types
	localparam logic [RTYPE_W-1:0] RT_NATIVE = 3'd0;
	localparam logic [RTYPE_W-1:0] RT_INT32  = 3'd1;
	localparam logic [RTYPE_W-1:0] RT_INT64  = 3'd2;
	localparam logic [RTYPE_W-1:0] RT_F32    = 3'd3;
	localparam logic [RTYPE_W-1:0] RT_F64    = 3'd4;

	typedef enum logic [1:0] {TGT_NONE, TGT_INT, TGT_F32, TGT_F64} tgt_t;
	typedef enum logic [1:0] {SRC_INT, SRC_F32, SRC_F64} src_t;

	// classified transaction handed from the front to the back
	typedef struct packed {
		tgt_t             tgt;
		src_t             src;
		logic             sgn;
		logic [6:0]       tb;
		logic [6:0]       rw;
		logic [6:0]       sw;
		logic [RTYPE_W-1:0] rtype;
		logic [VAL_W-1:0] raw;
	} dec_t;

	function automatic logic [63:0] low_mask(input logic [6:0] w);
		low_mask = (w >= 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	function automatic logic [63:0] ext(input logic [63:0] v, input logic [6:0] w,
		input logic sgn);
		logic [63:0] m;
		logic [63:0] r;
		m = low_mask(w);
		r = v & m;
		if (sgn && (w != 7'd0) && (w < 7'd64) && v[6'(w - 7'd1)]) r = r | ~m;
		ext = r;
	endfunction

endpackage

>>> rtl/cnu_ifs.sv
// Request and response channel interfaces of the numeric conversion unit.
interface cnu_req_if;
	import cnu_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [STYPE_W-1:0] src_type;
	logic [VAL_W-1:0]   src_value;
	modport source(output valid, command, src_type, src_value, input ready);
	modport sink(input valid, command, src_type, src_value, output ready);
endinterface

interface cnu_rsp_if;
	import cnu_pkg::*;
	logic               valid;
	logic               ready;
	logic [RTYPE_W-1:0] result_type;
	logic [VAL_W-1:0]   result_value;
	logic               out_of_range;
	modport source(output valid, result_type, result_value, out_of_range, input ready);
	modport sink(input valid, result_type, result_value, out_of_range, output ready);
endinterface

>>> rtl/cil_numeric_conversion_unit.sv
// Top level of the CIL conv-family numeric conversion unit.
//
// Channels: req carries one conversion transaction (command, src_type,
// src_value); rsp returns result_type, result_value and out_of_range.
// Both use valid/ready; a transaction moves at a rising edge where both
// are high.
//
// Throughput: one transaction per cycle while rsp.ready stays high. Path: a
// request passes the front register and the queue, then five back stages:
// unpack, two normalize steps, align, round/pack.
// The 64-bit leading-zero normalize is split over two stages; rounding
// and saturation share one aligning shifter.
//
// Reset (arst_n low) empties the front register, the queue and all back
// stages at once; no transaction is in flight afterwards.
// When the receiver holds rsp.ready low, the response register holds its
// transaction and the back stages fill up; the queue absorbs the rest and
// req.ready drops only once front, queue and pipeline are all full.
// Every transaction returns exactly one response, in order.
module cil_numeric_conversion_unit #(
	parameter int NATIVE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	cnu_req_if.sink   req,
	cnu_rsp_if.source rsp
);
	import cnu_pkg::*;

	dec_t front_dec, back_dec;
	logic front_valid, front_ready;
	logic back_valid, back_ready;

	// classify command and source type
	cnu_front #(.NATIVE_BITS(NATIVE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.dec       (front_dec),
		.dec_valid (front_valid),
		.dec_ready (front_ready)
	);

	// decouple front and back so each can stall on its own
	cnu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_dec    (front_dec),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_dec   (back_dec),
		.out_valid (back_valid),
		.out_ready (back_ready)
	);

	// convert, round or saturate, and drive the response
	cnu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec       (back_dec),
		.dec_valid (back_valid),
		.dec_ready (back_ready),
		.rsp       (rsp)
	);

endmodule

>>> rtl/cnu_front.sv
// Front part: accepts request transactions and classifies the command.
module cnu_front #(
	parameter int NATIVE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	cnu_req_if.sink       req,
	output cnu_pkg::dec_t dec,
	output logic          dec_valid,
	input  logic          dec_ready
);
	import cnu_pkg::*;

	localparam logic [6:0] NB = 7'(NATIVE_BITS);

	dec_t d;
	dec_t dec_q;
	logic dv_q;

	always_comb begin
		d       = '0;
		d.raw   = req.src_value;
		d.sgn   = (req.command <= CMD_U8) ? ~req.command[0] : (req.command != CMD_RUN);
		d.src   = (req.src_type == ST_F32) ? SRC_F32 :
		          (req.src_type == ST_F64) ? SRC_F64 : SRC_INT;
		d.sw    = (req.src_type == ST_INT32) ? 7'd32 :
		          (req.src_type == ST_INT64) ? 7'd64 : NB;
		unique case (req.command) inside
			CMD_I, CMD_U: begin
				d.tgt = TGT_INT; d.tb = NB; d.rw = NB; d.rtype = RT_NATIVE;
			end
			CMD_I1, CMD_U1: begin
				d.tgt = TGT_INT; d.tb = 7'd8; d.rw = 7'd32; d.rtype = RT_INT32;
			end
			CMD_I2, CMD_U2: begin
				d.tgt = TGT_INT; d.tb = 7'd16; d.rw = 7'd32; d.rtype = RT_INT32;
			end
			CMD_I4, CMD_U4: begin
				d.tgt = TGT_INT; d.tb = 7'd32; d.rw = 7'd32; d.rtype = RT_INT32;
			end
			CMD_I8, CMD_U8: begin
				d.tgt = TGT_INT; d.tb = 7'd64; d.rw = 7'd64; d.rtype = RT_INT64;
			end
			CMD_R4: begin
				d.tgt = TGT_F32; d.tb = 7'd64; d.rw = 7'd64; d.rtype = RT_F32;
			end
			CMD_R8, CMD_RUN: begin
				d.tgt = TGT_F64; d.tb = 7'd64; d.rw = 7'd64; d.rtype = RT_F64;
			end
			default: begin
				d.tgt = TGT_NONE; d.tb = 7'd64; d.rw = 7'd64; d.rtype = RT_NATIVE;
			end
		endcase
	end

	assign req.ready = ~dv_q | dec_ready;
	assign dec       = dec_q;
	assign dec_valid = dv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= 1'b0;
		end else if (req.ready) begin
			dv_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) dec_q <= d;
	end

endmodule

>>> rtl/cnu_queue.sv
// Short queue between the classifying front and the converting back.
module cnu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  cnu_pkg::dec_t in_dec,
	input  logic          in_valid,
	output logic          in_ready,
	output cnu_pkg::dec_t out_dec,
	output logic          out_valid,
	input  logic          out_ready
);
	import cnu_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(QDEPTH - 1);
	localparam logic [PW:0]   FULL = (PW + 1)'(QDEPTH);

	dec_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign in_ready  = (cnt_q != FULL);
	assign out_valid = (cnt_q != '0);
	assign out_dec   = mem_q[rd_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_dec;
	end

endmodule

>>> rtl/cnu_back.sv
// Back part: five-stage conversion pipeline ending in the response register.
module cnu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cnu_pkg::dec_t dec,
	input  logic          dec_valid,
	output logic          dec_ready,
	cnu_rsp_if.source     rsp
);
	import cnu_pkg::*;

	typedef struct packed {
		logic               early;
		logic [63:0]        eval;
		logic               eflag;
		tgt_t               tgt;
		logic               sgn;
		logic [6:0]         tb;
		logic [6:0]         rw;
		logic [RTYPE_W-1:0] rtype;
		logic               sign;
		logic signed [12:0] e;
	} ctl_t;

	function automatic logic [63:0] sat_val(input logic hi, input logic [6:0] tb,
		input logic sgn, input logic [6:0] rw);
		logic [63:0] v;
		if (hi) v = sgn ? low_mask(tb - 7'd1) : low_mask(tb);
		else    v = sgn ? ~low_mask(tb - 7'd1) : 64'd0;
		sat_val = ext(v, tb, sgn) & low_mask(rw);
	endfunction

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic r1, r2, r3, r4, r5;

	ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [63:0] mag_s1, norm_s2, norm_s3, kept_s4;
	logic [6:0]  lz_s2;
	logic        rnd_s4, stk_s4;

	assign r5        = ~v5_s5 | rsp.ready;
	assign r4        = ~v4_s4 | r5;
	assign r3        = ~v3_s3 | r4;
	assign r2        = ~v2_s2 | r3;
	assign r1        = ~v1_s1 | r2;
	assign dec_ready = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0; v2_s2 <= 1'b0; v3_s3 <= 1'b0; v4_s4 <= 1'b0; v5_s5 <= 1'b0;
		end else begin
			if (r1) v1_s1 <= dec_valid;
			if (r2) v2_s2 <= v1_s1;
			if (r3) v3_s3 <= v2_s2;
			if (r4) v4_s4 <= v3_s3;
			if (r5) v5_s5 <= v4_s4;
		end
	end

	// stage 1: unpack into sign, magnitude and exponent; settle the special cases
	ctl_t        c1;
	logic [63:0] m1;
	always_comb begin
		logic [63:0] iv;
		logic [7:0]  e8;
		logic [10:0] e11;
		logic        nan, inf, zero;
		iv   = ext(dec.raw, dec.sw, dec.sgn);
		e8   = dec.raw[30:23];
		e11  = dec.raw[62:52];
		c1   = '0;
		c1.tgt = dec.tgt; c1.sgn = dec.sgn; c1.tb = dec.tb; c1.rw = dec.rw;
		c1.rtype = dec.rtype;
		case (dec.src)
			SRC_F32: begin
				c1.sign = dec.raw[31];
				nan  = (&e8) & (|dec.raw[22:0]);
				inf  = (&e8) & ~(|dec.raw[22:0]);
				zero = ~(|e8) & ~(|dec.raw[22:0]);
				m1   = {40'd0, |e8, dec.raw[22:0]};
				c1.e = $signed({5'd0, (e8 == 8'd0) ? 8'd1 : e8}) - 13'sd150;
			end
			SRC_F64: begin
				c1.sign = dec.raw[63];
				nan  = (&e11) & (|dec.raw[51:0]);
				inf  = (&e11) & ~(|dec.raw[51:0]);
				zero = ~(|e11) & ~(|dec.raw[51:0]);
				m1   = {11'd0, |e11, dec.raw[51:0]};
				c1.e = $signed({2'd0, (e11 == 11'd0) ? 11'd1 : e11}) - 13'sd1075;
			end
			default: begin
				c1.sign = dec.sgn & iv[63];
				nan  = 1'b0;
				inf  = 1'b0;
				zero = (iv == 64'd0);
				m1   = c1.sign ? 64'd0 - iv : iv;
				c1.e = 13'sd0;
			end
		endcase
		case (dec.tgt)
			TGT_INT: begin
				c1.early = 1'b1;
				if (dec.src == SRC_INT) begin
					c1.eval = ext(iv, dec.tb, dec.sgn) & low_mask(dec.rw);
				end else if (nan) begin
					c1.eflag = 1'b1;
				end else if (inf) begin
					c1.eval  = sat_val(~c1.sign, dec.tb, dec.sgn, dec.rw);
					c1.eflag = 1'b1;
				end else begin
					c1.early = zero;
				end
			end
			TGT_F32: begin
				c1.early = 1'b1;
				if (dec.src == SRC_F32)  c1.eval = {32'd0, dec.raw[31:0]};
				else if (nan)            c1.eval = 64'h0000_0000_7FC0_0000;
				else if (inf)            c1.eval = {32'd0, c1.sign, 8'hFF, 23'd0};
				else if (zero)           c1.eval = {32'd0, c1.sign, 31'd0};
				else                     c1.early = 1'b0;
			end
			TGT_F64: begin
				c1.early = 1'b1;
				if (dec.src == SRC_F64)  c1.eval = dec.raw;
				else if (nan)            c1.eval = 64'h7FF8_0000_0000_0000;
				else if (inf)            c1.eval = {c1.sign, 11'h7FF, 52'd0};
				else if (zero)           c1.eval = {c1.sign, 63'd0};
				else                     c1.early = 1'b0;
			end
			default: c1.early = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (r1) begin
			ctl_s1 <= c1;
			mag_s1 <= m1;
		end
	end

	// stage 2: coarse normalize (32, 16, 8)
	always_ff @(posedge clk) begin
		logic [63:0] n;
		logic [6:0]  l;
		if (r2) begin
			n = mag_s1;
			l = 7'd0;
			if (n[63:32] == '0) begin n = {n[31:0], 32'd0}; l = l | 7'd32; end
			if (n[63:48] == '0) begin n = {n[47:0], 16'd0}; l = l | 7'd16; end
			if (n[63:56] == '0) begin n = {n[55:0], 8'd0};  l = l | 7'd8;  end
			norm_s2 <= n;
			lz_s2   <= l;
			ctl_s2  <= ctl_s1;
		end
	end

	// stage 3: fine normalize (4, 2, 1) and form the exponent of the leading one
	always_ff @(posedge clk) begin
		logic [63:0] n;
		logic [6:0]  l;
		ctl_t        c;
		if (r3) begin
			n = norm_s2;
			l = lz_s2;
			if (n[63:60] == '0) begin n = {n[59:0], 4'd0}; l = l | 7'd4; end
			if (n[63:62] == '0) begin n = {n[61:0], 2'd0}; l = l | 7'd2; end
			if (n[63] == 1'b0)  begin n = {n[62:0], 1'd0}; l = l | 7'd1; end
			c        = ctl_s2;
			c.e      = ctl_s2.e + 13'sd63 - $signed({6'd0, l});
			norm_s3  <= n;
			ctl_s3   <= c;
		end
	end

	// stage 4: align to the target (integer point or float precision)
	logic [6:0] sh4;
	always_comb begin
		logic signed [12:0] t;
		t = 13'sd0;
		case (ctl_s3.tgt)
			TGT_INT: begin
				if (ctl_s3.e < 13'sd0)       t = 13'sd127;
				else if (ctl_s3.e > 13'sd63) t = 13'sd0;
				else                         t = 13'sd63 - ctl_s3.e;
			end
			TGT_F32: t = 13'sd40 + ((ctl_s3.e < -13'sd126) ? (-13'sd126 - ctl_s3.e) : 13'sd0);
			TGT_F64: t = 13'sd11 + ((ctl_s3.e < -13'sd1022) ? (-13'sd1022 - ctl_s3.e) : 13'sd0);
			default: t = 13'sd0;
		endcase
		sh4 = (t > 13'sd127) ? 7'd127 : 7'(t);
	end

	always_ff @(posedge clk) begin
		logic [127:0] w;
		if (r4) begin
			w       = {norm_s3, 64'd0} >> sh4;
			kept_s4 <= w[127:64];
			rnd_s4  <= w[63];
			stk_s4  <= |w[62:0];
			ctl_s4  <= ctl_s3;
		end
	end

	// stage 5: saturate or round, pack, and hold in the response register
	logic [63:0] val5;
	logic        flag5;
	always_comb begin
		logic signed [12:0] tbm1;
		logic               hi, lo, inc;
		logic [63:0]        sum, packed_v;
		logic [11:0]        be;
		tbm1     = $signed({6'd0, ctl_s4.tb}) - 13'sd1;
		hi       = 1'b0;
		lo       = 1'b0;
		inc      = rnd_s4 & (stk_s4 | kept_s4[0]);
		sum      = kept_s4 + {63'd0, inc};
		be       = 12'd0;
		packed_v = 64'd0;
		val5     = ctl_s4.eval;
		flag5    = ctl_s4.eflag;
		if (!ctl_s4.early) begin
			case (ctl_s4.tgt)
				TGT_INT: begin
					if (ctl_s4.sgn) begin
						hi = ~ctl_s4.sign & (ctl_s4.e >= tbm1);
						lo = ctl_s4.sign & ((ctl_s4.e > tbm1) || ((ctl_s4.e == tbm1) &&
						     (kept_s4 != (64'd1 << (ctl_s4.tb - 7'd1)))));
					end else begin
						hi = ~ctl_s4.sign & (ctl_s4.e > tbm1);
						lo = ctl_s4.sign & (ctl_s4.e >= 13'sd0);
					end
					flag5 = hi | lo;
					if (hi | lo) val5 = sat_val(hi, ctl_s4.tb, ctl_s4.sgn, ctl_s4.rw);
					else val5 = ext(ctl_s4.sign ? 64'd0 - kept_s4 : kept_s4, ctl_s4.tb,
					                ctl_s4.sgn) & low_mask(ctl_s4.rw);
				end
				TGT_F32: begin
					if (ctl_s4.e >= -13'sd126) be = 12'(ctl_s4.e + 13'sd126);
					packed_v = ({52'd0, be} << 23) + sum;
					if ((ctl_s4.e > 13'sd127) || (packed_v >= 64'h7F80_0000))
						val5 = {32'd0, ctl_s4.sign, 8'hFF, 23'd0};
					else
						val5 = {32'd0, ctl_s4.sign, packed_v[30:0]};
				end
				TGT_F64: begin
					if (ctl_s4.e >= -13'sd1022) be = 12'(ctl_s4.e + 13'sd1022);
					packed_v = ({52'd0, be} << 52) + sum;
					if ((ctl_s4.e > 13'sd1023) || (packed_v >= 64'h7FF0_0000_0000_0000))
						val5 = {ctl_s4.sign, 11'h7FF, 52'd0};
					else
						val5 = {ctl_s4.sign, packed_v[62:0]};
				end
				default: val5 = 64'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (r5) begin
			rsp.result_type  <= ctl_s4.rtype;
			rsp.result_value <= val5;
			rsp.out_of_range <= flag5;
		end
	end

	assign rsp.valid = v5_s5;

endmodule

>>> rtl/cnu_checker.sv
// Port-level assertions for the numeric conversion unit, bound to the top level.
module cnu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_result_type,
	input logic [63:0] rsp_result_value,
	input logic        rsp_out_of_range
);
	import cnu_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) &&
		$stable(rsp_result_type) && $stable(rsp_out_of_range))
		else $error("stalled response changed");

	a_type: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_result_type <= RT_F64)
		else $error("result type out of range");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_out_of_range |-> (rsp_result_type == RT_NATIVE ||
		rsp_result_type == RT_INT32 || rsp_result_type == RT_INT64))
		else $error("out_of_range on a float result");

	a_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_result_type == RT_INT32 || rsp_result_type == RT_F32) |->
		rsp_result_value[63:32] == 32'd0)
		else $error("32-bit result has upper bits set");

endmodule

bind cil_numeric_conversion_unit cnu_checker u_cnu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_result_type  (rsp.result_type),
	.rsp_result_value (rsp.result_value),
	.rsp_out_of_range (rsp.out_of_range)
);

>>> tb/sv/cil_numeric_conversion_unit_tb.sv
// Self-checking testbench of the CIL numeric conversion unit.
module cil_numeric_conversion_unit_tb;
	import cnu_pkg::*;

	localparam int NATIVE_BITS = 32;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1880;

	typedef struct {
		logic [RTYPE_W-1:0] rtype;
		logic [VAL_W-1:0]   value;
		logic               oor;
	} conv_result_t;

	logic clk;
	logic arst_n;
	int   errors = 0;
	int   quiet_cycles = 0;
	bit   no_idle = 0;
	bit   hold_long = 0;
	conv_result_t expected_results[$];

	cnu_req_if req_if();
	cnu_rsp_if rsp_if();

	cil_numeric_conversion_unit #(.NATIVE_BITS(NATIVE_BITS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------------
	// Bit-level arithmetic of the predictor
	// ---------------------------------------------------------------------

	function automatic logic [63:0] width_mask(input int w);
		return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	function automatic logic [63:0] extend_bits(input logic [63:0] v, input int w, input bit sg);
		logic [63:0] r;
		r = v & width_mask(w);
		if (sg && w < 64 && r[w-1]) r = r | ~width_mask(w);
		return r;
	endfunction

	function automatic int msb_pos(input logic [63:0] v);
		int p;
		p = 63;
		while (p > 0 && !v[p]) p--;
		return p;
	endfunction

	// Round mag * 2^e to nearest-even in float32 or float64 and pack it.
	function automatic logic [63:0] round_pack(input logic sg, input logic [63:0] mag,
		input int e, input bit to32);
		int fb, bias, emax, p, q, s, ef;
		logic [64:0] mt;
		logic guard, sticky;
		fb = to32 ? 23 : 52;
		bias = to32 ? 127 : 1023;
		emax = to32 ? 255 : 2047;
		if (mag == 64'd0) return to32 ? {32'd0, sg, 31'd0} : {sg, 63'd0};
		p = msb_pos(mag);
		// quantum of the last kept bit: normal or clamped at the subnormal floor
		q = (((p + e) > (1 - bias)) ? (p + e) : (1 - bias)) - fb;
		s = q - e;
		guard = 1'b0;
		sticky = 1'b0;
		if (s <= 0) begin
			mt = {1'b0, mag} << (-s);
		end else if (s > 64) begin
			mt = '0;
			sticky = 1'b1;
		end else begin
			mt = {1'b0, mag} >> s;
			guard = mag[s-1];
			sticky = (s > 1) ? |(mag & ((64'd1 << (s - 1)) - 64'd1)) : 1'b0;
		end
		if (guard && (sticky || mt[0])) mt = mt + 65'd1;
		if (mt >= (65'd1 << (fb + 1))) begin
			mt = mt >> 1;
			q++;
		end
		ef = (mt < (65'd1 << fb)) ? 0 : q + fb + bias;
		if (ef >= emax) begin
			ef = emax;
			mt = '0;
		end
		if (to32) return {32'd0, sg, ef[7:0], mt[22:0]};
		return {sg, ef[10:0], mt[51:0]};
	endfunction

	// Split a float32 or float64 into sign, integer mantissa and exponent.
	function automatic void split_float(input logic [63:0] raw, input bit is32,
		output logic sg, output logic [63:0] mag, output int e,
		output bit is_nan, output bit is_inf);
		int ex;
		logic [63:0] fr;
		if (is32) begin
			sg = raw[31];
			ex = raw[30:23];
			fr = {41'd0, raw[22:0]};
			is_nan = (ex == 255) && (fr != 0);
			is_inf = (ex == 255) && (fr == 0);
			mag = (ex == 0) ? fr : (fr | (64'd1 << 23));
			e = (ex == 0) ? -149 : ex - 150;
		end else begin
			sg = raw[63];
			ex = raw[62:52];
			fr = {12'd0, raw[51:0]};
			is_nan = (ex == 2047) && (fr != 0);
			is_inf = (ex == 2047) && (fr == 0);
			mag = (ex == 0) ? fr : (fr | (64'd1 << 52));
			e = (ex == 0) ? -1074 : ex - 1075;
		end
	endfunction

	// Truncate toward zero to a b-bit integer, saturating out-of-range values.
	function automatic logic [63:0] truncate_float(input logic sg, input logic [63:0] mag,
		input int e, input bit is_inf, input int b, input bit signed_tgt, output bit sat);
		bit big;
		int p;
		logic [63:0] whole, half;
		big = is_inf;
		whole = '0;
		sat = 1'b0;
		if (!is_inf && mag != 0) begin
			p = msb_pos(mag);
			if (e >= 0) begin
				if (p + e >= 64) big = 1'b1;
				else whole = mag << e;
			end else begin
				whole = (-e >= 64) ? 64'd0 : (mag >> (-e));
			end
		end
		half = 64'd1 << (b - 1);
		if (signed_tgt) begin
			if (sg) begin
				if (big || whole > half) begin
					sat = 1'b1;
					return 64'd0 - half;
				end
				return 64'd0 - whole;
			end
			if (big || whole >= half) begin
				sat = 1'b1;
				return half - 64'd1;
			end
			return whole;
		end
		if (sg) begin
			sat = big || (whole != 0);
			return 64'd0;
		end
		if (big || (b < 64 && whole >= (64'd1 << b))) begin
			sat = 1'b1;
			return width_mask(b);
		end
		return whole;
	endfunction

	function automatic conv_result_t predict_conversion(input logic [CMD_W-1:0] cmd,
		input logic [STYPE_W-1:0] st, input logic [VAL_W-1:0] raw);
		conv_result_t r;
		bit sg, is_flt, is_nan, is_inf, sat;
		logic fsg;
		logic [63:0] mag, iv;
		int e, sw, tb, rw;
		r.rtype = RT_NATIVE;
		r.value = '0;
		r.oor = 1'b0;
		if (cmd > CMD_RUN) return r;
		sg = (cmd <= CMD_U8) ? !cmd[0] : (cmd != CMD_RUN);
		is_flt = (st == ST_F32) || (st == ST_F64);
		iv = '0;
		if (is_flt) begin
			split_float(raw, st == ST_F32, fsg, mag, e, is_nan, is_inf);
		end else begin
			sw = (st == ST_INT32) ? 32 : (st == ST_INT64) ? 64 : NATIVE_BITS;
			iv = extend_bits(raw, sw, sg);
		end
		if (cmd <= CMD_U8) begin
			if (cmd <= CMD_U) begin
				tb = NATIVE_BITS; rw = NATIVE_BITS; r.rtype = RT_NATIVE;
			end else if (cmd <= CMD_U4) begin
				tb = 8 << ((cmd - CMD_I1) >> 1); rw = 32; r.rtype = RT_INT32;
			end else begin
				tb = 64; rw = 64; r.rtype = RT_INT64;
			end
			if (is_flt) begin
				if (is_nan) begin
					iv = '0;
					r.oor = 1'b1;
				end else begin
					iv = truncate_float(fsg, mag, e, is_inf, tb, sg, sat);
					r.oor = sat;
				end
			end
			r.value = extend_bits(iv, tb, sg) & width_mask(rw);
		end else if (cmd == CMD_R4) begin
			r.rtype = RT_F32;
			if (st == ST_F32) r.value = {32'd0, raw[31:0]};
			else if (st == ST_F64 && is_nan) r.value = 64'h7FC0_0000;
			else if (st == ST_F64 && is_inf) r.value = {32'd0, fsg, 31'h7F80_0000};
			else if (st == ST_F64) r.value = round_pack(fsg, mag, e, 1'b1);
			else r.value = round_pack(iv[63], iv[63] ? 64'd0 - iv : iv, 0, 1'b1);
		end else begin
			r.rtype = RT_F64;
			if (st == ST_F64) r.value = raw;
			else if (st == ST_F32 && is_nan) r.value = 64'h7FF8_0000_0000_0000;
			else if (st == ST_F32 && is_inf) r.value = {fsg, 63'h7FF0_0000_0000_0000};
			else if (st == ST_F32) r.value = round_pack(fsg, mag, e, 1'b0);
			else if (sg) r.value = round_pack(iv[63], iv[63] ? 64'd0 - iv : iv, 0, 1'b0);
			else r.value = round_pack(1'b0, iv, 0, 1'b0);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Request driver, response receiver, checker, watchdog
	// ---------------------------------------------------------------------

	// Offer one conversion after a random gap; hold valid high afterwards so a
	// back-to-back transaction needs no second assignment in the same step.
	task automatic send_conversion(input logic [CMD_W-1:0] cmd, input logic [STYPE_W-1:0] st,
		input logic [VAL_W-1:0] val);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.command <= cmd;
		req_if.src_type <= st;
		req_if.src_value <= val;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (!req_if.ready);
		expected_results.push_back(predict_conversion(cmd, st, val));
	endtask

	// Hold until every expected result has come back.
	task automatic wait_drained();
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_long) begin
				// long back-pressure stretch: the pipeline and queue fill up
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_long = 1'b0;
			end
			n = no_idle ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	always @(posedge clk) begin
		conv_result_t exp_r;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result type=%0d value=%h oor=%b", $time,
					rsp_if.result_type, rsp_if.result_value, rsp_if.out_of_range);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (rsp_if.result_type !== exp_r.rtype) begin
					$display("%0t: result_type expected %0d actual %0d", $time,
						exp_r.rtype, rsp_if.result_type);
					errors++;
				end
				if (rsp_if.result_value !== exp_r.value) begin
					$display("%0t: result_value expected %h actual %h", $time,
						exp_r.value, rsp_if.result_value);
					errors++;
				end
				if (rsp_if.out_of_range !== exp_r.oor) begin
					$display("%0t: out_of_range expected %b actual %b", $time,
						exp_r.oor, rsp_if.out_of_range);
					errors++;
				end
			end
		end
	end

	// End the run when no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus generators
	// ---------------------------------------------------------------------

	function automatic logic [63:0] pick_frac(input int w);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return width_mask(w);
			default: return {$urandom, $urandom} & width_mask(w);
		endcase
	endfunction

	function automatic logic [63:0] gen_f64();
		int ex;
		logic [63:0] fr;
		case ($urandom_range(0, 5))
			0: ex = 1023 + $urandom_range(0, 66);
			1: ex = 1023 - $urandom_range(0, 30);
			2: ex = 1150 + $urandom_range(0, 2);
			3: ex = $urandom_range(0, 2);
			4: ex = 2047;
			default: ex = $urandom_range(0, 2047);
		endcase
		fr = pick_frac(52);
		return {$urandom_range(0, 1) == 1, ex[10:0], fr[51:0]};
	endfunction

	function automatic logic [63:0] gen_f32();
		int ex;
		logic [63:0] fr;
		case ($urandom_range(0, 4))
			0: ex = 127 + $urandom_range(0, 66);
			1: ex = 127 - $urandom_range(0, 30);
			2: ex = $urandom_range(0, 2);
			3: ex = 255;
			default: ex = $urandom_range(0, 255);
		endcase
		fr = pick_frac(23);
		return {$urandom, $urandom_range(0, 1) == 1, ex[7:0], fr[22:0]};
	endfunction

	function automatic logic [63:0] gen_int();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return v;
			1: return 64'd0 - 64'($urandom_range(0, 300));
			2: return 64'($urandom_range(0, 300));
			default: return v ^ (64'd1 << $urandom_range(0, 63)) ^ {64{v[0]}};
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Every command code once, the unused ones included, over all source types.
	task automatic test_each_command();
		for (int c = 0; c < 16; c++)
			send_conversion(c[CMD_W-1:0], c[STYPE_W-1:0],
				c[0] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_0000_8000_0080);
	endtask

	// Float corner cases: NaN, infinity, saturation edges, float32 overflow, plus integer-to-float edges.
	task automatic test_float_edges();
		send_conversion(CMD_I8, ST_F64, 64'h7FF8_0000_0000_0001);
		send_conversion(CMD_U8, ST_F64, 64'h7FF0_0000_0000_0000);
		send_conversion(CMD_U4, ST_F64, 64'hBFF0_0000_0000_0000);
		send_conversion(CMD_I8, ST_F64, 64'h43E0_0000_0000_0000);
		send_conversion(CMD_I8, ST_F64, 64'hC3E0_0000_0000_0000);
		send_conversion(CMD_U, ST_F64, 64'hBFE0_0000_0000_0000);
		send_conversion(CMD_R4, ST_F64, 64'h47EF_FFFF_F000_0000);
		send_conversion(CMD_R4, ST_F64, 64'h47EF_FFFF_E000_0000);
		send_conversion(CMD_R8, ST_F32, 64'h0000_0000_7FA0_0001);
		send_conversion(CMD_R4, ST_F32, 64'hDEAD_BEEF_7FA0_0001);
		send_conversion(CMD_RUN, ST_F64, 64'h7FF4_0000_0000_0000);
		send_conversion(CMD_I4, ST_F32, 64'h0000_0000_4F00_0000);
		send_conversion(CMD_RUN, ST_INT64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_conversion(CMD_R4, ST_INT64, 64'h8000_0000_0000_0000);
	endtask

	// Random conversions; a middle stretch runs with no idling on either side.
	task automatic test_random(input int count);
		logic [STYPE_W-1:0] st;
		logic [CMD_W-1:0] cmd;
		logic [VAL_W-1:0] val;
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= count / 3) && (i < count / 2);
			cmd = ($urandom_range(0, 15) == 0) ? CMD_W'($urandom_range(0, 15)) :
				CMD_W'($urandom_range(0, 12));
			st = STYPE_W'($urandom_range(0, 7));
			if (st == ST_F64) val = gen_f64();
			else if (st == ST_F32) val = gen_f32();
			else val = gen_int();
			send_conversion(cmd, st, val);
		end
		no_idle = 1'b0;
	endtask

	// Stall the receiver while the sender keeps offering, then drain fully.
	task automatic test_backpressure();
		hold_long = 1'b1;
		no_idle = 1'b1;
		for (int i = 0; i < 40; i++)
			send_conversion(CMD_W'($urandom_range(0, 12)), STYPE_W'($urandom_range(0, 7)),
				{$urandom, $urandom});
		no_idle = 1'b0;
		req_if.valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		req_if.valid <= 1'b0;
		req_if.command <= CMD_I;
		req_if.src_type <= ST_VALUETYPE;
		req_if.src_value <= '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_each_command();
		test_float_edges();
		test_backpressure();
		test_random(RANDOM_ITEMS);

		req_if.valid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
